// ===== rtl/core/esp_pkg.sv =====
// Package for the exFAT directory entry set parser.
// Holds the entry type codes, the parser mode and method codes, and the
// set and result record types. No dependencies.
package esp_pkg;

  localparam logic [6:0] TYPE_FILE     = 7'(8'h85 & 8'h7F);
  localparam logic [6:0] TYPE_STREAM   = 7'(8'hC0 & 8'h7F);
  localparam logic [6:0] TYPE_NAME     = 7'(8'hC1 & 8'h7F);
  localparam logic [7:0] TYPE_END      = 8'h00;
  localparam int unsigned IN_USE_BIT   = 7;
  localparam logic [7:0] MAX_SECONDARY = 8'd18;
  localparam int unsigned ATTR_RO_BIT  = 0;
  localparam int unsigned ATTR_DIR_BIT = 4;
  localparam int unsigned FLAG_NFC_BIT = 1;

  localparam logic CFG_SLACK_SCAN  = 1'b0;
  localparam logic CFG_REPORT_LIVE = 1'b1;

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_COLLECT,
    MODE_STOPPED
  } parse_mode_t;

  typedef enum logic [1:0] {
    METHOD_NONE,
    METHOD_CONTIG,
    METHOD_CHAIN,
    METHOD_DELETED
  } method_t;

  typedef struct packed {
    logic        in_use;
    logic [15:0] attributes;
    logic        have_stream;
    logic [7:0]  flags;
    logic [7:0]  name_length;
    logic [31:0] first_cluster;
    logic [63:0] valid_length;
    logic [63:0] data_length;
  } set_t;

  typedef struct packed {
    logic [31:0] first_cluster;
    logic [63:0] data_length;
    logic [63:0] recovered_size;
    logic [7:0]  name_length;
    logic        is_dir;
    logic        was_deleted;
    logic        read_only;
    logic        no_fat_chain;
    logic        sparse;
    logic        descend;
    logic        report;
    method_t     method;
  } result_t;

endpackage

// ===== rtl/core/esp_emit.sv =====
// Builds the result record for a finished entry set.
// Depends on esp_pkg for the set and result types.
module esp_emit (
  input  esp_pkg::set_t    set,
  input  logic             report_live,
  output esp_pkg::result_t res
);
  import esp_pkg::*;

  logic live;
  logic dir;
  logic nfc;
  logic has_cluster;
  logic regular;

  always_comb begin
    live        = set.in_use;
    dir         = set.attributes[ATTR_DIR_BIT];
    nfc         = set.flags[FLAG_NFC_BIT];
    has_cluster = |set.first_cluster[31:1];
    regular     = !dir && has_cluster;

    res                = '0;
    res.first_cluster  = set.first_cluster;
    res.data_length    = set.data_length;
    res.recovered_size = set.data_length;
    res.name_length    = set.name_length;
    res.is_dir         = dir;
    res.was_deleted    = !live;
    res.read_only      = set.attributes[ATTR_RO_BIT];
    res.no_fat_chain   = nfc;
    res.descend        = dir && live && has_cluster;
    res.report         = !live || report_live;
    res.method         = METHOD_NONE;
    if (regular) begin
      if (nfc) begin
        res.method = METHOD_CONTIG;
      end else if (live) begin
        res.method = METHOD_CHAIN;
      end else begin
        res.method = METHOD_DELETED;
      end
      if ((set.valid_length != 64'd0) && (set.valid_length < set.data_length)) begin
        res.recovered_size = set.valid_length;
        res.sparse         = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/exfat_entry_set_parser_core.sv =====
// An accepted entry is held in the input register; a finished set goes to the result register.
// It takes one entry per cycle while the input does not stall, as the parser state updates once per entry.
// An input register and a result register part the two channels; the input side
// stalls only when both are full and the output is stalled.
// Reset (rst, synchronous): clears the valid bits of both registers, the parser state and both
// configuration bits; no clearing pass.
module exfat_entry_set_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] entry_word0,
  input  logic [63:0] entry_word1,
  input  logic [63:0] entry_word2,
  input  logic [63:0] entry_word3,
  input  logic        last_in_directory,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] first_cluster,
  output logic [63:0] data_length,
  output logic [63:0] recovered_size,
  output logic [7:0]  name_length,
  output logic        is_dir,
  output logic        was_deleted,
  output logic        read_only,
  output logic        no_fat_chain,
  output logic        sparse,
  output logic        descend,
  output logic        report,
  output logic [1:0]  method
);
  import esp_pkg::*;

  logic        slack_scan;
  logic        report_live;

  logic        p_valid;
  logic [63:0] p_word0;
  logic [63:0] p_word1;
  logic [63:0] p_word2;
  logic [63:0] p_word3;
  logic        p_last;

  parse_mode_t parse_mode;
  parse_mode_t parse_mode_next;
  logic [4:0]  secondaries_left;
  logic [4:0]  secondaries_left_next;
  set_t        set;
  set_t        set_next;
  set_t        coll;

  logic        res_valid;
  result_t     res;
  result_t     res_new;

  logic        advance;
  logic        accept;
  logic        emit;
  logic        handle_primary;
  logic [7:0]  etype;
  logic [6:0]  base;
  logic [7:0]  count;
  logic        is_sec;

  assign advance  = !res_valid || !out_stall;
  assign in_stall = p_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slack_scan  <= 1'b0;
      report_live <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLACK_SCAN:  slack_scan  <= cfg_data;
        CFG_REPORT_LIVE: report_live <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (advance) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_word0 <= entry_word0;
      p_word1 <= entry_word1;
      p_word2 <= entry_word2;
      p_word3 <= entry_word3;
      p_last  <= last_in_directory;
    end
  end

  always_comb begin
    etype  = p_word0[7:0];
    base   = etype[6:0];
    count  = p_word0[15:8];
    is_sec = (base == TYPE_STREAM) || (base == TYPE_NAME);

    coll = set;
    if (base == TYPE_STREAM) begin
      coll.flags         = p_word0[15:8];
      coll.name_length   = p_word0[31:24];
      coll.valid_length  = p_word1;
      coll.first_cluster = p_word2[63:32];
      coll.data_length   = p_word3;
      coll.have_stream   = 1'b1;
    end

    parse_mode_next       = parse_mode;
    secondaries_left_next = secondaries_left;
    set_next              = set;
    emit                  = 1'b0;
    handle_primary        = 1'b1;

    unique case (parse_mode)
      MODE_COLLECT: begin
        if (is_sec) begin
          set_next              = coll;
          secondaries_left_next = secondaries_left - 5'd1;
          handle_primary        = 1'b0;
          if ((secondaries_left_next == 5'd0) || p_last) begin
            emit            = 1'b1;
            parse_mode_next = MODE_SCAN;
          end
        end else begin
          emit            = 1'b1;
          parse_mode_next = MODE_SCAN;
        end
      end
      MODE_STOPPED: handle_primary = 1'b0;
      default:      parse_mode_next = MODE_SCAN;
    endcase

    if (handle_primary) begin
      if (etype == TYPE_END) begin
        if (!slack_scan) begin
          parse_mode_next = MODE_STOPPED;
        end
      end else if ((base == TYPE_FILE) && (count != 8'd0) && (count <= MAX_SECONDARY)) begin
        parse_mode_next       = MODE_COLLECT;
        secondaries_left_next = count[4:0];
        set_next              = '0;
        set_next.in_use       = etype[IN_USE_BIT];
        set_next.attributes   = p_word0[47:32];
      end
    end

    if (p_last) begin
      parse_mode_next = MODE_SCAN;
    end
  end

  esp_emit u_emit (
    .set         (coll),
    .report_live (report_live),
    .res         (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode       <= MODE_SCAN;
      secondaries_left <= '0;
      set              <= '0;
      res_valid        <= 1'b0;
    end else if (advance) begin
      res_valid <= p_valid && emit && coll.have_stream;
      if (p_valid) begin
        parse_mode       <= parse_mode_next;
        secondaries_left <= secondaries_left_next;
        set              <= set_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p_valid && emit) begin
      res <= res_new;
    end
  end

  assign out_valid      = res_valid;
  assign first_cluster  = res.first_cluster;
  assign data_length    = res.data_length;
  assign recovered_size = res.recovered_size;
  assign name_length    = res.name_length;
  assign is_dir         = res.is_dir;
  assign was_deleted    = res.was_deleted;
  assign read_only      = res.read_only;
  assign no_fat_chain   = res.no_fat_chain;
  assign sparse         = res.sparse;
  assign descend        = res.descend;
  assign report         = res.report;
  assign method         = res.method;

endmodule
